// ----- rtl/itc_pkg.sv -----
// Shared types and codes for the three-channel interval timer.
package itc_pkg;

  // Item action codes; the fourth code is a no-op.
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Command register port.
  localparam logic [1:0] CMD_PORT = 2'd3;

  // Channel access modes.
  localparam logic [1:0] AM_LATCH  = 2'd0;
  localparam logic [1:0] AM_LOW    = 2'd1;
  localparam logic [1:0] AM_HIGH   = 2'd2;
  localparam logic [1:0] AM_TOGGLE = 2'd3;

  localparam logic [15:0] RELOAD_MAX = 16'hFFFF;

  // Per-channel strobes decoded from one word.
  typedef struct packed {
    logic       rd;
    logic       wr;
    logic       cmd;
    logic       tick;
    logic [7:0] data;
  } chan_op_t;

endpackage

// ----- rtl/itc_channel.sv -----
// One counter channel: reload, count, latch, mode and byte toggle.
module itc_channel (
  input  logic             clk,
  input  logic             rst,
  input  itc_pkg::chan_op_t op,
  output logic [7:0]       rd_byte,
  output logic             reloaded
);
  import itc_pkg::*;

  logic        enabled;
  logic        toggle;
  logic [15:0] count;
  logic [15:0] latch;
  logic [15:0] reload;
  logic [1:0]  mode;

  logic        pick_high;
  logic        paired;
  logic [15:0] latch_view;
  logic [15:0] reload_hi;

  always_comb begin
    unique case (mode)
      AM_LOW:  pick_high = 1'b0;
      AM_HIGH: pick_high = 1'b1;
      default: pick_high = toggle;
    endcase
    paired     = (mode == AM_LATCH) || (mode == AM_TOGGLE);
    // non-latch modes read through a fresh snapshot of the count
    latch_view = (mode != AM_LATCH) ? count : latch;
    reload_hi  = {op.data, reload[7:0]};
    rd_byte    = !op.rd ? 8'd0 : (pick_high ? latch_view[15:8] : latch_view[7:0]);
    reloaded   = op.tick && enabled && (count == 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      toggle  <= 1'b0;
      count   <= 16'd0;
      latch   <= 16'd0;
      reload  <= 16'd0;
      mode    <= AM_LATCH;
    end else begin
      if (op.rd) begin
        latch <= latch_view;
        if (paired) toggle <= !toggle;
      end
      if (op.wr) begin
        if (pick_high) begin
          enabled <= 1'b1;
          reload  <= (reload_hi == 16'd0) ? RELOAD_MAX : reload_hi;
        end else begin
          enabled <= 1'b0;
          reload  <= {reload[15:8], op.data};
        end
        if (paired) toggle <= !toggle;
      end
      if (op.cmd) begin
        toggle <= 1'b0;
        mode   <= op.data[5:4];
        if (op.data[5:4] == AM_LATCH) latch <= count;
      end
      if (op.tick && enabled) begin
        count <= (count == 16'd0) ? reload : count - 16'd1;
      end
    end
  end

endmodule

// ----- rtl/interval_timer_three_channel.sv -----
// Interval timer, three 16-bit down counters with byte-wide bus access.
// An accepted word passes through the input register and then the result register.
// Throughput: one word per cycle while out_ready holds; all channels update in parallel in one pass.
// Stage 1 advances whenever the result register is empty or being drained.
// Reset (rst, synchronous, active high) clears all channel state and both stages.
module interval_timer_three_channel #(
  parameter int NUM_CHANNELS = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [1:0] port,
  input  logic [7:0] wr_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] rd_byte,
  output logic       irq0
);
  import itc_pkg::*;

  // input register
  logic       s1_valid;
  logic [1:0] s1_action;
  logic [1:0] s1_port;
  logic [7:0] s1_byte;

  logic       advance;
  logic [1:0] cmd_ch;
  logic       cmd_ok;

  chan_op_t   ops      [NUM_CHANNELS];
  logic [7:0] ch_byte  [NUM_CHANNELS];
  logic       ch_rel   [NUM_CHANNELS];

  logic [7:0] rd_byte_next;
  logic       irq0_next;

  // stage 1 moves into the result register when that is free or being taken
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_port   <= port;
      s1_byte   <= wr_byte;
    end
  end

  // command byte: channel in 7:6; select beyond the channel count is dropped
  assign cmd_ch = s1_byte[7:6];
  assign cmd_ok = (32'(cmd_ch) < NUM_CHANNELS);

  // decode one word into per-channel strobes
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      ops[i].rd   = advance && (s1_action == ACT_READ) && (s1_port == 2'(i));
      ops[i].wr   = advance && (s1_action == ACT_WRITE) && (s1_port == 2'(i));
      ops[i].cmd  = advance && (s1_action == ACT_WRITE) && (s1_port == CMD_PORT)
                    && cmd_ok && (cmd_ch == 2'(i));
      ops[i].tick = advance && (s1_action == ACT_TICK);
      ops[i].data = s1_byte;
    end
  end

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
    itc_channel u_chan (
      .clk      (clk),
      .rst      (rst),
      .op       (ops[g]),
      .rd_byte  (ch_byte[g]),
      .reloaded (ch_rel[g])
    );
  end

  // at most one channel drives a nonzero read byte
  always_comb begin
    rd_byte_next = 8'd0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      rd_byte_next = rd_byte_next | ch_byte[i];
    end
    irq0_next = ch_rel[0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_byte <= rd_byte_next;
      irq0    <= irq0_next;
    end
  end

  // a tick never carries read data
  a_irq_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && irq0 |-> rd_byte == 8'd0)
    else $error("irq0 with nonzero read byte");

  // only a tick can raise irq0
  a_irq_from_tick: assert property (@(posedge clk) disable iff (rst)
    advance && s1_action != ACT_TICK |=> !irq0)
    else $error("irq0 from non-tick word");

  // an accepted word always lands in stage 1
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted word lost");

endmodule

// ----- test/tb_interval_timer_three_channel.sv -----
// Self-checking testbench for the three-channel interval timer.
module tb_interval_timer_three_channel;
  import itc_pkg::*;

  localparam int         NUM_CH   = 3;
  localparam logic [1:0] ACT_NOP  = 2'd3;  // fourth action code, does nothing
  localparam logic [1:0] CH_NONE  = 2'd3;  // channel field value that selects nothing
  localparam int         RAND_WORDS = 800;

  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
  } timer_result_t;

  // Shadow copy of the timer: tracks channel state word by word and
  // keeps the results still owed by the block, oldest first.
  class timer_shadow;
    bit            enabled[NUM_CH];
    bit            toggle[NUM_CH];
    bit [15:0]     count[NUM_CH];
    bit [15:0]     latch[NUM_CH];
    bit [15:0]     reload[NUM_CH];
    bit [1:0]      mode[NUM_CH];
    timer_result_t pending[$];
    int unsigned   errors;

    // Latch and toggle modes alternate bytes; low and high modes are fixed.
    function bit high_sel(input int ch);
      if (mode[ch] == AM_LOW) return 1'b0;
      if (mode[ch] == AM_HIGH) return 1'b1;
      return toggle[ch];
    endfunction

    function void flip_toggle(input int ch);
      if (mode[ch] == AM_LATCH || mode[ch] == AM_TOGGLE) toggle[ch] = !toggle[ch];
    endfunction

    function void flag(input string what);
      errors++;
      if (errors <= 10) $display("%0t ERROR: %s", $time, what);
    endfunction

    // Accepted input word: advance the shadow state and queue the result.
    function void note_word(input logic [1:0] act, input logic [1:0] prt,
                            input logic [7:0] b);
      timer_result_t res;
      int            ch;
      res = '0;
      case (act)
        ACT_READ: begin
          if (prt != CMD_PORT) begin
            if (mode[prt] != AM_LATCH) latch[prt] = count[prt];
            res.rd = high_sel(prt) ? latch[prt][15:8] : latch[prt][7:0];
            flip_toggle(prt);
          end
        end
        ACT_WRITE: begin
          if (prt == CMD_PORT) begin
            ch = b[7:6];
            if (ch < NUM_CH) begin
              toggle[ch] = 1'b0;
              mode[ch]   = b[5:4];
              if (mode[ch] == AM_LATCH) latch[ch] = count[ch];
            end
          end else begin
            if (high_sel(prt)) begin
              reload[prt][15:8] = b;
              enabled[prt]      = 1'b1;
              if (reload[prt] == 16'h0000) reload[prt] = RELOAD_MAX;
            end else begin
              reload[prt][7:0] = b;
              enabled[prt]     = 1'b0;
            end
            flip_toggle(prt);
          end
        end
        ACT_TICK: begin
          for (int i = 0; i < NUM_CH; i++) begin
            if (enabled[i]) begin
              if (count[i] == 16'h0000) begin
                count[i] = reload[i];
                if (i == 0) res.irq = 1'b1;
              end else begin
                count[i] = count[i] - 16'd1;
              end
            end
          end
        end
        default: ;
      endcase
      pending.push_back(res);
    endfunction

    function void check_result(input logic [7:0] rd, input logic irq);
      timer_result_t want;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result rd_byte %02h irq0 %0b", rd, irq));
        return;
      end
      want = pending.pop_front();
      if (rd !== want.rd || irq !== want.irq)
        flag($sformatf("rd_byte exp %02h got %02h, irq0 exp %0b got %0b",
                       want.rd, rd, want.irq, irq));
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] action;
  logic [1:0] port;
  logic [7:0] wr_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] rd_byte;
  logic       irq0;

  timer_shadow shadow;
  int unsigned burst_left;
  int unsigned words_sent;

  interval_timer_three_channel #(.NUM_CHANNELS(NUM_CH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .port     (port),
    .wr_byte  (wr_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rd_byte  (rd_byte),
    .irq0     (irq0)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("interval_timer_three_channel verification failed");
    $finish;
  end

  // Sender: words go out in bursts; valid stays high across a burst and
  // drops between bursts.
  task automatic send_word(input logic [1:0] act, input logic [1:0] prt,
                           input logic [7:0] b);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    action   <= act;
    port     <= prt;
    wr_byte  <= b;
    do @(posedge clk); while (!in_ready);
    shadow.note_word(act, prt, b);
    words_sent++;
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  // Hold the sender off until every queued result has come back.
  task automatic wait_drained();
    if (burst_left != 0) begin
      in_valid   <= 1'b0;
      burst_left = 0;
    end
    while (shadow.pending.size() != 0) @(posedge clk);
  endtask

  // Command word, then the data bytes its access mode expects. Small
  // reloads dominate so channel 0 wraps often and raises irq0.
  task automatic program_channel();
    logic [1:0]  ch;
    logic [1:0]  md;
    logic [1:0]  prt;
    logic [15:0] value;
    ch    = ($urandom_range(0, 11) == 0) ? CH_NONE : 2'($urandom_range(0, 2));
    md    = 2'($urandom_range(0, 3));
    send_word(ACT_WRITE, CMD_PORT, {ch, md, 4'($urandom)});
    prt   = (ch == CH_NONE) ? 2'($urandom_range(0, 2)) : ch;
    value = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    case (md)
      AM_LOW: send_word(ACT_WRITE, prt, value[7:0]);
      AM_HIGH: send_word(ACT_WRITE, prt, value[15:8]);
      default: begin
        send_word(ACT_WRITE, prt, value[7:0]);
        // occasionally leave the channel disabled after the low byte
        if ($urandom_range(0, 7) != 0) send_word(ACT_WRITE, prt, value[15:8]);
      end
    endcase
  endtask

  // Optional mode change (latch mode snapshots the count), then reads.
  task automatic read_channel();
    logic [1:0] prt;
    prt = ($urandom_range(0, 9) == 0) ? CMD_PORT : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 1) == 1)
      send_word(ACT_WRITE, CMD_PORT, {prt, 2'($urandom_range(0, 3)), 4'($urandom)});
    repeat ($urandom_range(1, 4)) send_word(ACT_READ, prt, 8'($urandom));
  endtask

  // Receiver: checks at each accepted result and stalls following a 16-bit
  // ready mask that is itself redrawn at random.
  initial begin : result_side
    logic [15:0] stall_mask;
    int unsigned phase;
    out_ready  = 1'b0;
    stall_mask = 16'hFFFF;
    phase      = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) shadow.check_result(rd_byte, irq0);
      phase++;
      if (phase % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_mask = 16'hFFFF;
          1: stall_mask = 16'($urandom);
          2: stall_mask = 16'($urandom) | 16'($urandom);
          default: stall_mask = 16'($urandom) & 16'($urandom);
        endcase
      end
      out_ready <= stall_mask[phase % 16];
    end
  end

  initial begin : stimulus
    int unsigned rand_start;
    shadow     = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    action     = ACT_READ;
    port       = 2'd0;
    wr_byte    = 8'h00;
    burst_left = 0;
    words_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: command port read, no-op action, ignored channel select.
    send_word(ACT_READ, CMD_PORT, 8'h00);
    send_word(ACT_NOP, 2'd2, 8'hFF);
    send_word(ACT_WRITE, CMD_PORT, {CH_NONE, AM_TOGGLE, 4'h0});
    // Channel 0, toggle mode, reload 3: wraps on the first tick, then every fourth.
    send_word(ACT_WRITE, CMD_PORT, {2'd0, AM_TOGGLE, 4'h0});
    send_word(ACT_WRITE, 2'd0, 8'h03);
    send_word(ACT_WRITE, 2'd0, 8'h00);
    repeat (5) send_word(ACT_TICK, 2'd0, 8'h00);
    // Channel 1, high mode, zero reload turns into the maximum.
    send_word(ACT_WRITE, CMD_PORT, {2'd1, AM_HIGH, 4'hF});
    send_word(ACT_WRITE, 2'd1, 8'h00);
    // Channel 2, low mode: low byte write leaves it disabled.
    send_word(ACT_WRITE, CMD_PORT, {2'd2, AM_LOW, 4'h0});
    send_word(ACT_WRITE, 2'd2, 8'hFF);
    send_word(ACT_TICK, 2'd3, 8'hFF);
    // Latch mode: snapshot held while the counter keeps moving.
    send_word(ACT_WRITE, CMD_PORT, {2'd1, AM_LATCH, 4'h0});
    send_word(ACT_TICK, 2'd0, 8'h00);
    send_word(ACT_READ, 2'd1, 8'h00);
    send_word(ACT_READ, 2'd1, 8'h00);
    // Fixed-byte reads and a disabled channel read.
    send_word(ACT_WRITE, CMD_PORT, {2'd0, AM_LOW, 4'h0});
    send_word(ACT_READ, 2'd0, 8'h00);
    send_word(ACT_WRITE, CMD_PORT, {2'd0, AM_HIGH, 4'h0});
    send_word(ACT_READ, 2'd0, 8'h00);
    send_word(ACT_READ, 2'd2, 8'h00);
    send_word(ACT_NOP, CMD_PORT, 8'h00);
    wait_drained();

    // Random: mostly well-formed programming, tick runs and reads,
    // some raw noise, and an occasional full drain.
    rand_start = words_sent;
    while (words_sent - rand_start < RAND_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: program_channel();
        3, 4, 5: repeat ($urandom_range(1, 24)) send_word(ACT_TICK, 2'($urandom),
                                                          8'($urandom));
        6, 7: read_channel();
        8: repeat ($urandom_range(1, 4))
             send_word(2'($urandom), 2'($urandom), 8'($urandom));
        default: begin
          if ($urandom_range(0, 3) == 0) wait_drained();
          else send_word(2'($urandom), 2'($urandom), 8'($urandom));
        end
      endcase
    end

    wait_drained();
    // Let a stray late result show up before the verdict.
    repeat (10) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending.size() == 0) begin
      $display("interval_timer_three_channel verification clean");
    end else begin
      $display("interval_timer_three_channel verification failed");
    end
    $finish;
  end

endmodule
